// ===== hdl/lcst_pkg.sv =====
// ----------------------------------------------------------------------------
// lcst_pkg
// Shared widths, codes and payload types of the load-cell serial reader.
// ----------------------------------------------------------------------------
package lcst_pkg;

    // converter word and derived datapath widths
    localparam int DATA_BITS          = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;
    localparam int GAIN_W             = 32;
    localparam int TIMEOUT_W          = 24;
    localparam int COUNT_W            = 8;
    localparam int PHASE_W            = 6;
    localparam int SUM_W              = DATA_BITS + COUNT_W;
    localparam int MAG_W              = DATA_BITS + 1;
    localparam int HI_W               = MAG_W + 1;
    localparam int LO_W               = SUM_W;
    localparam int PROD_W             = HI_W + LO_W;
    localparam int STEP_W             = $clog2(LO_W);
    localparam int WEIGHT_W           = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_SAMPLES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RECIP     = 2'd2;

    localparam logic [COUNT_W-1:0]   TARE_SAMPLES_RST   = 8'd10;
    localparam logic [TIMEOUT_W-1:0] SAMPLE_TIMEOUT_RST = 24'd100000;
    localparam logic [GAIN_W-1:0]    GAIN_RECIP_RST     = 32'h0001_0000;

    // saturation limits of the weight
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

    // shared unit operations
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic dout;
        logic mode;
    } t_in_item;

    typedef struct packed {
        logic                       sck;
        logic                       sample_valid;
        logic signed [DATA_BITS-1:0] raw_value;
        logic signed [WEIGHT_W-1:0]  weight;
        logic                       connected;
        logic                       tare_busy;
    } t_out_item;

    // status of the tick sequencer after one tick
    typedef struct packed {
        logic sck;
        logic sample_valid;
        logic div_req;
        logic tare_busy;
        logic connected;
    } t_tick_stat;

    typedef struct packed {
        logic start;
        logic op;
    } t_mdu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_stat;

endpackage

// ===== hdl/lcst_stream_if.sv =====
// ----------------------------------------------------------------------------
// lcst_stream_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface lcst_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/lcst_muldiv.sv =====
// ----------------------------------------------------------------------------
// lcst_muldiv
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module lcst_muldiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lcst_pkg::t_mdu_cmd          i_cmd,
    input  logic [lcst_pkg::HI_W-1:0]   i_addend,
    input  logic [lcst_pkg::LO_W-1:0]   i_lo_init,
    output lcst_pkg::t_mdu_stat         o_stat,
    output logic [lcst_pkg::PROD_W-1:0] o_prod
);
    import lcst_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_op, n_op;
    logic [STEP_W-1:0] r_step, n_step;
    logic [HI_W-1:0]   r_hi, n_hi;
    logic [LO_W-1:0]   r_lo, n_lo;
    logic [HI_W-1:0]   r_addend, n_addend;

    logic [HI_W-1:0]   op_a;
    logic [HI_W-1:0]   op_b;
    logic              carry_in;
    logic [HI_W:0]     sum;

    // one adder: accumulate for multiply, trial subtract for divide
    always_comb begin
        if (r_op == OP_MUL) begin
            op_a     = r_hi;
            op_b     = r_lo[0] ? r_addend : '0;
            carry_in = 1'b0;
        end else begin
            op_a     = {r_hi[HI_W-2:0], r_lo[LO_W-1]};
            op_b     = ~r_addend;
            carry_in = 1'b1;
        end
        sum = {1'b0, op_a} + {1'b0, op_b} + {{HI_W{1'b0}}, carry_in};
    end

    // load on start, then step until the counter runs out
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_op     = r_op;
        n_step   = r_step;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_addend = r_addend;
        if (i_cmd.start && !r_busy) begin
            n_busy   = 1'b1;
            n_op     = i_cmd.op;
            n_step   = STEP_W'(LO_W - 1);
            n_hi     = '0;
            n_lo     = i_lo_init;
            n_addend = i_addend;
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                n_hi = sum[HI_W:1];
                n_lo = {sum[0], r_lo[LO_W-1:1]};
            end else begin
                n_hi = sum[HI_W] ? sum[HI_W-1:0] : op_a;
                n_lo = {r_lo[LO_W-2:0], sum[HI_W]};
            end
            n_step = r_step - 1'b1;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op     <= n_op;
        r_step   <= n_step;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_addend <= n_addend;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = {r_hi, r_lo};

endmodule

// ===== hdl/lcst_tick.sv =====
// ----------------------------------------------------------------------------
// lcst_tick
// Tick sequencer: converter read, serial shift-in and tare accumulation.
// ----------------------------------------------------------------------------
module lcst_tick (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  lcst_pkg::t_in_item               i_item,
    input  logic [lcst_pkg::COUNT_W-1:0]     i_tare_samples,
    input  logic [lcst_pkg::TIMEOUT_W-1:0]   i_timeout,
    output lcst_pkg::t_tick_stat             o_stat,
    output logic [lcst_pkg::DATA_BITS-1:0]   o_last_raw,
    output logic [lcst_pkg::SUM_W-1:0]       o_tare_sum,
    output logic [lcst_pkg::COUNT_W-1:0]     o_tare_count
);
    import lcst_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_TWAIT = 3'd2;
    localparam logic [2:0] ST_TREAD = 3'd3;

    localparam logic [PHASE_W-1:0]   PHASE_LAST = PHASE_W'(2 * DATA_BITS + 1);
    localparam logic [PHASE_W-2:0]   SHIFT_BITS = (PHASE_W - 1)'(DATA_BITS);

    logic [2:0]           r_state, n_state;
    logic [PHASE_W-1:0]   r_phase, n_phase;
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic [DATA_BITS-1:0] r_last, n_last;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [COUNT_W-1:0]   r_cnt, n_cnt;
    logic [COUNT_W-1:0]   r_att, n_att;
    logic [TIMEOUT_W-1:0] r_wait, n_wait;
    logic                 r_conn, n_conn;
    logic                 r_sck, n_sck;
    logic                 r_valid, n_valid;
    logic                 r_div, n_div;

    logic [COUNT_W-1:0]   att_inc;
    logic                 att_end;
    logic [TIMEOUT_W:0]   wait_inc;

    // apply one tick
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_shift = r_shift;
        n_last  = r_last;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_att   = r_att;
        n_wait  = r_wait;
        n_conn  = r_conn;
        n_sck   = 1'b0;
        n_valid = 1'b0;
        n_div   = 1'b0;
        att_inc  = r_att + 1'b1;
        att_end  = (att_inc == '0) || (att_inc >= i_tare_samples);
        wait_inc = {1'b0, r_wait} + 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (i_item.mode && i_tare_samples != '0) begin
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_att   = '0;
                    n_wait  = '0;
                    n_state = ST_TWAIT;
                end else if (!i_item.dout) begin
                    n_phase = '0;
                    n_shift = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ, ST_TREAD: begin
                if (!r_phase[0]) begin
                    // SCK high: sample data, extra pulse selects gain
                    n_sck = 1'b1;
                    if (r_phase[PHASE_W-1:1] < SHIFT_BITS) begin
                        n_shift = {r_shift[DATA_BITS-2:0], i_item.dout};
                    end
                    n_phase = r_phase + 1'b1;
                end else if (r_phase >= PHASE_LAST) begin
                    n_phase = '0;
                    if (r_state == ST_READ) begin
                        n_last  = r_shift;
                        n_conn  = 1'b1;
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_sum = r_sum + {{(SUM_W - DATA_BITS){r_shift[DATA_BITS-1]}}, r_shift};
                        n_cnt = r_cnt + 1'b1;
                        n_att = att_inc;
                        if (att_end) begin
                            n_div   = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_wait  = '0;
                            n_state = ST_TWAIT;
                        end
                    end
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            ST_TWAIT: begin
                if (!i_item.dout) begin
                    n_phase = '0;
                    n_shift = '0;
                    n_state = ST_TREAD;
                end else if (wait_inc >= {1'b0, i_timeout}) begin
                    // skip this attempt on timeout
                    n_att = att_inc;
                    if (att_end) begin
                        n_div   = (r_cnt != '0);
                        n_state = ST_IDLE;
                    end else begin
                        n_wait  = '0;
                        n_state = ST_TWAIT;
                    end
                end else begin
                    n_wait = wait_inc[TIMEOUT_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_shift <= '0;
            r_last  <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_att   <= '0;
            r_wait  <= '0;
            r_conn  <= 1'b0;
            r_sck   <= 1'b0;
            r_valid <= 1'b0;
            r_div   <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_last  <= n_last;
            r_sum   <= n_sum;
            r_cnt   <= n_cnt;
            r_att   <= n_att;
            r_wait  <= n_wait;
            r_conn  <= n_conn;
            r_sck   <= n_sck;
            r_valid <= n_valid;
            r_div   <= n_div;
        end
    end

    assign o_stat.sck          = r_sck;
    assign o_stat.sample_valid = r_valid;
    assign o_stat.div_req      = r_div;
    assign o_stat.tare_busy    = (r_state == ST_TWAIT) || (r_state == ST_TREAD);
    assign o_stat.connected    = r_conn;
    assign o_last_raw          = r_last;
    assign o_tare_sum          = r_sum;
    assign o_tare_count        = r_cnt;

endmodule

// ===== hdl/load_cell_serial_reader_tare.sv =====
// ----------------------------------------------------------------------------
// load_cell_serial_reader_tare
// Load-cell converter reader with tare averaging and fixed-point scaling.
// ----------------------------------------------------------------------------
// Each input request is one SCK half-period tick with the converter's data
// line and a tare request bit; each tick yields exactly one result request
// with the SCK level, the read status, the last raw sample and the tared,
// scaled weight. A tick advances the tick sequencer, then runs the shift-add
// multiply of the weight in the shared multiply/divide unit, then sign
// handling, rounding and saturation. A tick that closes a tare with at
// least one valid sample first runs a restoring divide of the tare sum in
// the same unit. Input ready is low while a tick is worked on; a finished
// result sits in an output register, so the next tick may enter before the
// result is taken. Configuration writes are taken at any time but are meant
// for idle periods.
// ----------------------------------------------------------------------------
module load_cell_serial_reader_tare #(
    parameter int GAIN_FRAC_BITS = lcst_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lcst_stream_if.sink                        i_in,
    lcst_stream_if.source                      o_out,
    input  logic                               i_cfg_we,
    input  logic [lcst_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcst_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import lcst_pkg::*;

    localparam int QW = PROD_W - GAIN_FRAC_BITS;

    localparam logic [3:0] SQ_IDLE   = 4'd0;
    localparam logic [3:0] SQ_EVAL   = 4'd1;
    localparam logic [3:0] SQ_DIV    = 4'd2;
    localparam logic [3:0] SQ_PREP   = 4'd3;
    localparam logic [3:0] SQ_MSTART = 4'd4;
    localparam logic [3:0] SQ_MUL    = 4'd5;
    localparam logic [3:0] SQ_RND    = 4'd6;
    localparam logic [3:0] SQ_SAT    = 4'd7;
    localparam logic [3:0] SQ_OUT    = 4'd8;

    // configuration registers
    logic [COUNT_W-1:0]   r_tare_samples;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [GAIN_W-1:0]    r_gain;

    // sequencer and datapath registers
    logic [3:0]           r_seq, n_seq;
    logic [DATA_BITS-1:0] r_offset, n_offset;
    logic                 r_div_neg, n_div_neg;
    logic [MAG_W-1:0]     r_diff, n_diff;
    logic [QW-1:0]        r_q, n_q;
    logic [WEIGHT_W-1:0]  r_weight, n_weight;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 in_take;
    t_tick_stat           tick_stat;
    logic [DATA_BITS-1:0] last_raw;
    logic [SUM_W-1:0]     tare_sum;
    logic [COUNT_W-1:0]   tare_count;

    t_mdu_cmd             mdu_cmd;
    t_mdu_stat            mdu_stat;
    logic [HI_W-1:0]      mdu_addend;
    logic [LO_W-1:0]      mdu_lo_init;
    logic [PROD_W-1:0]    mdu_prod;

    logic                 diff_neg;
    logic [MAG_W-1:0]     diff_mag;
    logic [SUM_W-1:0]     sum_mag;
    logic [DATA_BITS-1:0] quot;
    logic                 q_big;

    assign in_take    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_seq == SQ_IDLE);

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare_samples <= TARE_SAMPLES_RST;
            r_timeout      <= SAMPLE_TIMEOUT_RST;
            r_gain         <= GAIN_RECIP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARE_SAMPLES:   r_tare_samples <= i_cfg_wdata[COUNT_W-1:0];
                CFG_SAMPLE_TIMEOUT: r_timeout      <= i_cfg_wdata[TIMEOUT_W-1:0];
                CFG_GAIN_RECIP:     r_gain         <= i_cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lcst_tick u_tick (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_take),
        .i_item         (i_in.payload),
        .i_tare_samples (r_tare_samples),
        .i_timeout      (r_timeout),
        .o_stat         (tick_stat),
        .o_last_raw     (last_raw),
        .o_tare_sum     (tare_sum),
        .o_tare_count   (tare_count)
    );

    lcst_muldiv u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mdu_cmd),
        .i_addend  (mdu_addend),
        .i_lo_init (mdu_lo_init),
        .o_stat    (mdu_stat),
        .o_prod    (mdu_prod)
    );

    // operand preparation
    assign diff_neg = r_diff[MAG_W-1];
    assign diff_mag = diff_neg ? (MAG_W'(0) - r_diff) : r_diff;
    assign sum_mag  = tare_sum[SUM_W-1] ? (SUM_W'(0) - tare_sum) : tare_sum;
    assign quot     = mdu_prod[DATA_BITS-1:0];
    assign q_big    = |r_q[QW-1:WEIGHT_W-1];

    // shared unit commands
    always_comb begin
        mdu_cmd.start = 1'b0;
        mdu_cmd.op    = OP_MUL;
        mdu_addend    = HI_W'(diff_mag);
        mdu_lo_init   = LO_W'(r_gain);
        if (r_seq == SQ_EVAL && tick_stat.div_req) begin
            mdu_cmd.start = 1'b1;
            mdu_cmd.op    = OP_DIV;
            mdu_addend    = HI_W'(tare_count);
            mdu_lo_init   = LO_W'(sum_mag);
        end else if (r_seq == SQ_MSTART) begin
            mdu_cmd.start = 1'b1;
        end
    end

    // sequence one tick through offset update, scaling and output
    always_comb begin
        n_seq       = r_seq;
        n_offset    = r_offset;
        n_div_neg   = r_div_neg;
        n_diff      = r_diff;
        n_q         = r_q;
        n_weight    = r_weight;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_seq)
            SQ_IDLE: begin
                if (in_take) begin
                    n_seq = SQ_EVAL;
                end
            end
            SQ_EVAL: begin
                n_div_neg = tare_sum[SUM_W-1];
                n_seq     = tick_stat.div_req ? SQ_DIV : SQ_PREP;
            end
            SQ_DIV: begin
                if (mdu_stat.done) begin
                    n_offset = r_div_neg ? (DATA_BITS'(0) - quot) : quot;
                    n_seq    = SQ_PREP;
                end
            end
            SQ_PREP: begin
                n_diff = {last_raw[DATA_BITS-1], last_raw} - {r_offset[DATA_BITS-1], r_offset};
                n_seq  = SQ_MSTART;
            end
            SQ_MSTART: begin
                n_seq = SQ_MUL;
            end
            SQ_MUL: begin
                if (mdu_stat.done) begin
                    n_seq = SQ_RND;
                end
            end
            SQ_RND: begin
                // round the negative product toward minus infinity
                n_q   = mdu_prod[PROD_W-1:GAIN_FRAC_BITS]
                      + {{(QW - 1){1'b0}}, diff_neg && (|mdu_prod[GAIN_FRAC_BITS-1:0])};
                n_seq = SQ_SAT;
            end
            SQ_SAT: begin
                if (r_gain == '0) begin
                    n_weight = '0;
                end else if (diff_neg) begin
                    n_weight = q_big ? WEIGHT_MIN : (WEIGHT_W'(0) - r_q[WEIGHT_W-1:0]);
                end else begin
                    n_weight = q_big ? WEIGHT_MAX : r_q[WEIGHT_W-1:0];
                end
                n_seq = SQ_OUT;
            end
            SQ_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out.sck          = tick_stat.sck;
                    n_out.sample_valid = tick_stat.sample_valid;
                    n_out.raw_value    = last_raw;
                    n_out.weight       = r_weight;
                    n_out.connected    = tick_stat.connected;
                    n_out.tare_busy    = tick_stat.tare_busy;
                    n_out_valid        = 1'b1;
                    n_seq              = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_offset    <= n_offset;
            r_out_valid <= n_out_valid;
        end
        r_div_neg <= n_div_neg;
        r_diff    <= n_diff;
        r_q       <= n_q;
        r_weight  <= n_weight;
        r_out     <= n_out;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the load-cell serial reader with tare.
// ----------------------------------------------------------------------------
// Converter ticks are sent as whole read and tare sequences with random
// data, between bursts of idle ticks. A scoreboard class tracks the reader
// state, the tare averaging and the scaled weight for each accepted tick, and
// checks every result field in order. The sender idles in bursts and the
// receiver stalls on its own pattern. Registers change between phases, once
// every result is in, and cover gain extremes, zero tare count and timeouts.
// ----------------------------------------------------------------------------
module tb_top;
    import lcst_pkg::*;

    localparam int N_TICKS      = 850;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 4000;
    localparam int END_CYCLES   = 100;
    localparam int LAST_PHASE   = 2 * DATA_BITS + 1;
    localparam int READ_TICKS   = 2 * DATA_BITS + 2;

    typedef enum logic [1:0] {
        RDR_IDLE,
        RDR_READ,
        RDR_TWAIT,
        RDR_TREAD
    } t_reader_state;

    // Track reader state and hold the results due, oldest first
    class t_reader_scoreboard;
        logic [COUNT_W-1:0]          n_tare;
        logic [TIMEOUT_W-1:0]        tmo;
        logic [GAIN_W-1:0]           recip;
        t_reader_state               st;
        logic [PHASE_W-1:0]          phase;
        logic [DATA_BITS-1:0]        shreg;
        logic signed [DATA_BITS-1:0] raw;
        logic signed [DATA_BITS-1:0] offset;
        longint                      sum;
        logic [COUNT_W-1:0]          nvalid;
        logic [COUNT_W-1:0]          attempts;
        logic [TIMEOUT_W-1:0]        wcnt;
        logic                        conn;
        t_out_item                   due_q[$];
        int                          n_err;

        function void clear();
            n_tare   = TARE_SAMPLES_RST;
            tmo      = SAMPLE_TIMEOUT_RST;
            recip    = GAIN_RECIP_RST;
            st       = RDR_IDLE;
            phase    = '0;
            shreg    = '0;
            raw      = '0;
            offset   = '0;
            sum      = 0;
            nvalid   = '0;
            attempts = '0;
            wcnt     = '0;
            conn     = 1'b0;
            n_err    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TARE_SAMPLES:   n_tare = val[COUNT_W-1:0];
                CFG_SAMPLE_TIMEOUT: tmo    = val[TIMEOUT_W-1:0];
                CFG_GAIN_RECIP:     recip  = val[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Close one tare attempt; average at the end of the run
        function void close_attempt();
            attempts = attempts + 1'b1;
            if (attempts == 0 || attempts >= n_tare) begin
                if (nvalid != 0)
                    offset = DATA_BITS'(sum / longint'(nvalid));
                st = RDR_IDLE;
            end else begin
                wcnt = '0;
                st   = RDR_TWAIT;
            end
        endfunction

        // Tared difference times Q16.16 gain, floor, saturated
        function logic [WEIGHT_W-1:0] scaled_weight();
            longint      diff;
            logic [63:0] mag;
            logic [63:0] prod;
            logic [63:0] q;
            bit          neg;
            diff = longint'(raw) - longint'(offset);
            neg  = (diff < 0);
            mag  = neg ? 64'(-diff) : 64'(diff);
            if (recip == 0)
                return '0;
            prod = mag * {32'b0, recip};
            q    = prod >> GAIN_FRAC_BITS_DEF;
            if (neg) begin
                if (prod[GAIN_FRAC_BITS_DEF-1:0] != 0)
                    q = q + 1;
                if (q >= 64'h8000_0000)
                    return WEIGHT_MIN;
                return WEIGHT_W'(64'd0 - q);
            end
            if (q > 64'h7FFF_FFFF)
                return WEIGHT_MAX;
            return WEIGHT_W'(q);
        endfunction

        // Advance one tick and queue the result it yields
        function void note_request(t_in_item it);
            t_out_item                   r;
            logic                        sck;
            logic                        vld;
            logic signed [DATA_BITS-1:0] word;
            sck = 1'b0;
            vld = 1'b0;
            case (st)
                RDR_IDLE: begin
                    if (it.mode && n_tare != 0) begin
                        sum      = 0;
                        nvalid   = '0;
                        attempts = '0;
                        wcnt     = '0;
                        st       = RDR_TWAIT;
                    end else if (!it.dout) begin
                        phase = '0;
                        shreg = '0;
                        st    = RDR_READ;
                    end
                end
                RDR_READ, RDR_TREAD: begin
                    if (!phase[0]) begin
                        sck = 1'b1;
                        if ((phase >> 1) < DATA_BITS)
                            shreg = {shreg[DATA_BITS-2:0], it.dout};
                        phase = phase + 1'b1;
                    end else if (phase >= LAST_PHASE) begin
                        word  = shreg;
                        phase = '0;
                        if (st == RDR_READ) begin
                            raw  = word;
                            conn = 1'b1;
                            vld  = 1'b1;
                            st   = RDR_IDLE;
                        end else begin
                            sum    = sum + word;
                            nvalid = nvalid + 1'b1;
                            close_attempt();
                        end
                    end else begin
                        phase = phase + 1'b1;
                    end
                end
                RDR_TWAIT: begin
                    if (!it.dout) begin
                        phase = '0;
                        shreg = '0;
                        st    = RDR_TREAD;
                    end else if (int'(wcnt) + 1 >= int'(tmo)) begin
                        close_attempt();
                    end else begin
                        wcnt = wcnt + 1'b1;
                    end
                end
                default: st = RDR_IDLE;
            endcase
            r.sck          = sck;
            r.sample_valid = vld;
            r.raw_value    = raw;
            r.weight       = scaled_weight();
            r.connected    = conn;
            r.tare_busy    = (st == RDR_TWAIT || st == RDR_TREAD);
            due_q.push_back(r);
        endfunction

        // Compare one result with the oldest one due
        function void check_result(t_out_item got);
            t_out_item want;
            if (due_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: result with none due: sck=%0d vld=%0d raw=%0d wt=%0d",
                             got.sck, got.sample_valid, got.raw_value, got.weight);
                return;
            end
            want = due_q.pop_front();
            if (got.sck !== want.sck || got.sample_valid !== want.sample_valid ||
                got.raw_value !== want.raw_value || got.weight !== want.weight ||
                got.connected !== want.connected || got.tare_busy !== want.tare_busy) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("ERROR: mismatch exp sck=%0d vld=%0d raw=%0d wt=%0d con=%0d busy=%0d",
                             want.sck, want.sample_valid, want.raw_value, want.weight,
                             want.connected, want.tare_busy);
                    $display("       got sck=%0d vld=%0d raw=%0d wt=%0d con=%0d busy=%0d",
                             got.sck, got.sample_valid, got.raw_value, got.weight,
                             got.connected, got.tare_busy);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    lcst_stream_if #(.t_payload(t_in_item))  in_if ();
    lcst_stream_if #(.t_payload(t_out_item)) out_if ();

    load_cell_serial_reader_tare DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_reader_scoreboard   sb;
    t_in_item             tick_q[$];
    int                   n_sent;
    int                   idle_cycles;
    bit                   hold_pending;
    logic [COUNT_W-1:0]   gen_samples;
    logic [TIMEOUT_W-1:0] gen_timeout;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Note accepted ticks and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_request(in_if.payload);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.payload);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall in segments of random style, hold off once on request
    initial begin : rx_proc
        int seg_left;
        int style;
        bit held;
        seg_left = 0;
        style    = 0;
        held     = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending && !held) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    style    = $urandom_range(0, 3);
                    seg_left = $urandom_range(4, 64);
                end
                seg_left--;
                case (style)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    2:       out_if.ready <= ($urandom_range(0, 7) == 0);
                    default: out_if.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Write one register and keep the generator's view in step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        sb.write_reg(idx, val);
        if (idx == CFG_TARE_SAMPLES)
            gen_samples = val[COUNT_W-1:0];
        else if (idx == CFG_SAMPLE_TIMEOUT)
            gen_timeout = val[TIMEOUT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_tick(input logic dout, input logic mode);
        t_in_item it;
        it.dout = dout;
        it.mode = mode;
        tick_q.push_back(it);
    endtask

    function automatic logic [DATA_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2:       return 24'h00_0000;
            3:       return 24'hFF_FFFF;
            default: return DATA_BITS'($urandom);
        endcase
    endfunction

    // Pulse ticks of one read; data bits land on the SCK-high ticks
    task automatic push_read_body(input logic [DATA_BITS-1:0] word);
        int k;
        for (k = 0; k < READ_TICKS; k++) begin
            if (k % 2 == 0 && k / 2 < DATA_BITS)
                push_tick(word[DATA_BITS-1-k/2], 1'($urandom_range(0, 1)));
            else
                push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Plain read; with a zero tare count the start tick may carry mode 1
    task automatic push_read(input logic [DATA_BITS-1:0] word);
        push_tick(1'b0, (gen_samples == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
        push_read_body(word);
    endtask

    // Idle ticks with the data line high
    task automatic push_noise(input int n);
        repeat (n) push_tick(1'b1, (gen_samples == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
    endtask

    // Full tare: each attempt either times out or reads after a short wait
    task automatic push_tare();
        int  span;
        int  a;
        int  j;
        bit  do_read;
        span = (gen_timeout == 0) ? 1 : int'(gen_timeout);
        push_tick(1'($urandom_range(0, 1)), 1'b1);
        for (a = 0; a < int'(gen_samples); a++) begin
            if (span > 64)
                do_read = 1'b1;
            else if (gen_samples > 8)
                do_read = ($urandom_range(0, 39) == 0);
            else
                do_read = $urandom_range(0, 1);
            if (do_read) begin
                j = $urandom_range(0, (span - 1 < 5) ? span - 1 : 5);
                repeat (j) push_tick(1'b1, 1'($urandom_range(0, 1)));
                push_tick(1'b0, 1'($urandom_range(0, 1)));
                push_read_body(pick_word());
            end else begin
                repeat (span) push_tick(1'b1, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Send the queued ticks in bursts with random gaps
    task automatic play_ticks();
        t_in_item it;
        int       burst;
        int       gap;
        burst = $urandom_range(1, 40);
        while (tick_q.size() != 0) begin
            it = tick_q.pop_front();
            in_if.valid   <= 1'b1;
            in_if.payload <= it;
            do @(posedge i_clk); while (in_if.ready !== 1'b1);
            n_sent++;
            burst--;
            if (tick_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap != 0) begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // Hold until every result is in; the first edge lets the last request be noted
    task automatic wait_drained(input int pause);
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (pause) @(posedge i_clk);
    endtask

    // New register setting for the next phase
    task automatic pick_config();
        logic [GAIN_W-1:0] g;
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       g = '0;
                1:       g = 32'hFFFF_FFFF;
                2:       g = GAIN_RECIP_RST;
                3, 4:    g = $urandom;
                default: g = $urandom_range(1, 32'h0003_0000);
            endcase
            write_reg(CFG_GAIN_RECIP, g);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0: begin
                    write_reg(CFG_TARE_SAMPLES, 0);
                    write_reg(CFG_SAMPLE_TIMEOUT, $urandom_range(0, 12));
                end
                1: begin
                    write_reg(CFG_TARE_SAMPLES, 255);
                    write_reg(CFG_SAMPLE_TIMEOUT, $urandom_range(0, 1));
                end
                2: begin
                    write_reg(CFG_TARE_SAMPLES, $urandom_range(1, 3));
                    write_reg(CFG_SAMPLE_TIMEOUT, 24'hFF_FFFF);
                end
                3: begin
                    write_reg(CFG_TARE_SAMPLES, $urandom_range(1, 3));
                    write_reg(CFG_SAMPLE_TIMEOUT, $urandom & 32'h00FF_FFFF);
                end
                default: begin
                    write_reg(CFG_TARE_SAMPLES, $urandom_range(1, 4));
                    write_reg(CFG_SAMPLE_TIMEOUT, $urandom_range(0, 12));
                end
            endcase
        end
    endtask

    // Main sequence
    initial begin
        int n_seq;
        int s;
        sb = new;
        sb.clear();
        n_sent        = 0;
        hold_pending  = 1'b0;
        gen_samples   = TARE_SAMPLES_RST;
        gen_timeout   = SAMPLE_TIMEOUT_RST;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_wdata   <= '0;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-scale reads at reset gain
        push_noise(2);
        push_read(24'h7F_FFFF);
        push_read(24'h80_0000);
        play_ticks();
        wait_drained(4);

        // Saturating gain; zero tare count makes mode 1 a plain tick
        write_reg(CFG_GAIN_RECIP, 32'hFFFF_FFFF);
        write_reg(CFG_TARE_SAMPLES, 0);
        push_tick(1'b1, 1'b1);
        push_read(24'h7F_FFFF);
        push_read(24'h80_0000);
        play_ticks();
        wait_drained(4);

        // Zero gain, zero timeout; tare wins over ready, one skip then a read
        write_reg(CFG_GAIN_RECIP, 0);
        write_reg(CFG_TARE_SAMPLES, 2);
        write_reg(CFG_SAMPLE_TIMEOUT, 0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_read_body(24'h12_34AB);
        play_ticks();
        wait_drained(4);

        // Tare with every attempt skipped keeps the offset
        write_reg(CFG_GAIN_RECIP, GAIN_RECIP_RST);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_read(24'h00_0000);
        play_ticks();
        wait_drained(4);

        // Random phases; the first one runs under a long receiver hold-off
        hold_pending = 1'b1;
        while (n_sent < N_TICKS) begin
            n_seq = $urandom_range(1, 4);
            for (s = 0; s < n_seq && n_sent + tick_q.size() < N_TICKS; s++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: push_read(pick_word());
                    5, 6, 7: begin
                        if (gen_samples != 0)
                            push_tare();
                        else
                            push_read(pick_word());
                    end
                    default: push_noise($urandom_range(1, 6));
                endcase
            end
            play_ticks();
            wait_drained(4);
            pick_config();
        end

        wait_drained(END_CYCLES);
        if (sb.n_err == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
